[src/ffba_pkg.sv]
// Shared definitions for the first-fit block allocator.
// Holds field widths, command codes and the sequencer state type.
// No dependencies.
package ffba_pkg;

  // Fixed widths of the command and result fields
  localparam int OP_W     = 2;
  localparam int REQ_W    = 16;
  localparam int OFFSET_W = 12;

  // Command codes
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_INIT  = 2'd2;

  // Sequencer states, one-hot
  typedef enum logic [10:0] {
    S_INIT    = 11'b00000000001,
    S_IDLE    = 11'b00000000010,
    S_A_RD    = 11'b00000000100,
    S_A_CHK   = 11'b00000001000,
    S_A_SPLIT = 11'b00000010000,
    S_A_MARK  = 11'b00000100000,
    S_F_RD    = 11'b00001000000,
    S_F_CHK   = 11'b00010000000,
    S_C_RD    = 11'b00100000000,
    S_C_CHK   = 11'b01000000000,
    S_C_NCHK  = 11'b10000000000
  } state_t;

endpackage

[src/ffba_div.sv]
// Splits a byte count into whole granules and the bytes left over.
// The granule size is a power of two, so this is a shift and a mask.
// Depends on ffba_pkg.
module ffba_div import ffba_pkg::*; #(
  parameter int DIVISOR = 16
) (
  input  logic [REQ_W-1:0]             dividend,
  output logic [REQ_W-1:0]             quotient,
  output logic [$clog2(DIVISOR)-1:0]   remainder
);

  localparam int SHIFT = $clog2(DIVISOR);

  // Drop the low bits for the granule count, keep them as the remainder
  assign quotient  = dividend >> SHIFT;
  assign remainder = dividend[SHIFT-1:0];

endmodule

[src/first_fit_block_allocator_top.sv]
// First-fit allocator over an arena of granules with one header granule per block.
// Each command takes one pulse on start while busy is low; its single result appears
// on done/success/granted_offset for exactly one cycle and cannot be held off. After
// reset, busy stays high for one cycle while the first header is written. The granule
// size must be a power of two; requests and offsets are split into granules by a shift.
// Allocate walks the header memory through its single registered read port, reading
// and checking one header at a time; on a hit it carves the tail off as a new free
// block when at least two granules are left over, then marks the block used. Release
// walks to its block and marks it free, then coalesces in one pass, merging each free
// block with the free neighbors that follow it.
// Reinit, null or misaligned release and the unused code raise done in the cycle
// after acceptance. Busy is low again in the cycle done is high. At the default
// sizes there are at most 128 blocks.
// Depends on ffba_pkg and ffba_div.
module first_fit_block_allocator_top import ffba_pkg::*; #(
  parameter int ARENA_BYTES   = 4096,
  parameter int GRANULE_BYTES = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [OP_W-1:0]     op,
  input  logic [REQ_W-1:0]    request_bytes,
  input  logic [OFFSET_W-1:0] release_offset,
  output logic                done,
  output logic                success,
  output logic [OFFSET_W-1:0] granted_offset
);

  localparam int GRANULES = ARENA_BYTES / GRANULE_BYTES;
  localparam int IW = (GRANULES > 1) ? $clog2(GRANULES) : 1;
  localparam int SW = IW;
  localparam int PW = $clog2(GRANULES + 1) + 1;
  localparam int CW = REQ_W + 1;
  localparam int RW = $clog2(GRANULE_BYTES);
  localparam int MW = (PW + 7 > OFFSET_W) ? PW + 7 : OFFSET_W;

  // Header memory: {free, payload size in granules}
  logic [SW:0] mem [GRANULES];

  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic [SW:0]   rd_data;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [SW:0]   wr_data;

  logic          rd_free;
  logic [SW-1:0] rd_size;

  state_t state, state_next;
  logic [PW-1:0]    pos, pos_next;
  logic [REQ_W-1:0] target, target_next;
  logic [CW-1:0]    need, need_next;
  logic [SW-1:0]    cur_size, cur_size_next;

  logic                fin;
  logic                fin_ok;
  logic [OFFSET_W-1:0] fin_off;

  logic [REQ_W-1:0] div_dividend;
  logic [REQ_W-1:0] div_quo;
  logic [RW-1:0]    div_rem;

  logic [PW-1:0] foll;
  logic [SW-1:0] merged;
  logic [PW-1:0] merged_foll;
  logic [CW-1:0] split_pos;
  logic [MW-1:0] offset_full;
  logic          at_end;

  assign rd_free = rd_data[SW];
  assign rd_size = rd_data[SW-1:0];

  // Header arithmetic
  assign foll        = pos + PW'(1) + PW'(rd_size);
  assign merged      = cur_size + SW'(1) + rd_size;
  assign merged_foll = pos + PW'(1) + PW'(merged);
  assign split_pos   = CW'(pos) + CW'(1) + need;
  assign offset_full = (MW'(pos) + MW'(1)) * MW'(GRANULE_BYTES);
  assign at_end      = (pos >= PW'(GRANULES));

  // Round allocate requests up by dividing one less; releases divide as given
  assign div_dividend = (op == OP_ALLOC) ?
                        ((request_bytes == '0) ? '0 : request_bytes - REQ_W'(1)) :
                        REQ_W'(release_offset);

  ffba_div #(
    .DIVISOR (GRANULE_BYTES)
  ) u_div (
    .dividend  (div_dividend),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Hold the header store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Sequence one transaction through the walk and header updates
  always_comb begin
    state_next    = state;
    pos_next      = pos;
    target_next   = target;
    need_next     = need;
    cur_size_next = cur_size;
    rd_en         = 1'b0;
    rd_addr       = pos[IW-1:0];
    wr_en         = 1'b0;
    wr_addr       = pos[IW-1:0];
    wr_data       = '0;
    fin           = 1'b0;
    fin_ok        = 1'b0;
    fin_off       = '0;

    case (state)
      S_INIT: begin
        wr_en      = 1'b1;
        wr_addr    = '0;
        wr_data    = {1'b1, SW'(GRANULES - 1)};
        state_next = S_IDLE;
      end

      S_IDLE: begin
        if (start) begin
          pos_next = '0;
          case (op)
            OP_ALLOC: begin
              need_next  = CW'(div_quo) + CW'(1);
              state_next = S_A_RD;
            end
            OP_FREE: begin
              if (release_offset == '0 || div_rem != '0) begin
                // Null or misaligned release: ignore it
                fin    = 1'b1;
                fin_ok = 1'b1;
              end else begin
                target_next = div_quo - REQ_W'(1);
                state_next  = S_F_RD;
              end
            end
            OP_INIT: begin
              wr_en   = 1'b1;
              wr_addr = '0;
              wr_data = {1'b1, SW'(GRANULES - 1)};
              fin     = 1'b1;
              fin_ok  = 1'b1;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end

      S_A_RD: begin
        if (at_end) begin
          fin        = 1'b1;
          state_next = S_IDLE;
        end else begin
          rd_en      = 1'b1;
          state_next = S_A_CHK;
        end
      end

      S_A_CHK: begin
        cur_size_next = rd_size;
        if (rd_free && (CW'(rd_size) >= need)) begin
          state_next = (CW'(rd_size) >= need + CW'(2)) ? S_A_SPLIT : S_A_MARK;
        end else begin
          pos_next   = foll;
          state_next = S_A_RD;
        end
      end

      S_A_SPLIT: begin
        // Carve the tail off as a new free block
        wr_en         = 1'b1;
        wr_addr       = split_pos[IW-1:0];
        wr_data       = {1'b1, cur_size - SW'(need) - SW'(1)};
        cur_size_next = SW'(need);
        state_next    = S_A_MARK;
      end

      S_A_MARK: begin
        wr_en      = 1'b1;
        wr_data    = {1'b0, cur_size};
        fin        = 1'b1;
        fin_ok     = 1'b1;
        fin_off    = offset_full[OFFSET_W-1:0];
        state_next = S_IDLE;
      end

      S_F_RD: begin
        if (at_end) begin
          fin        = 1'b1;
          fin_ok     = 1'b1;
          state_next = S_IDLE;
        end else begin
          rd_en      = 1'b1;
          state_next = S_F_CHK;
        end
      end

      S_F_CHK: begin
        if (CW'(pos) == CW'(target)) begin
          wr_en      = 1'b1;
          wr_data    = {1'b1, rd_size};
          pos_next   = '0;
          state_next = S_C_RD;
        end else if (CW'(pos) > CW'(target)) begin
          // Not a block start: ignore the release
          fin        = 1'b1;
          fin_ok     = 1'b1;
          state_next = S_IDLE;
        end else begin
          pos_next   = foll;
          state_next = S_F_RD;
        end
      end

      S_C_RD: begin
        if (at_end) begin
          fin        = 1'b1;
          fin_ok     = 1'b1;
          state_next = S_IDLE;
        end else begin
          rd_en      = 1'b1;
          state_next = S_C_CHK;
        end
      end

      S_C_CHK: begin
        cur_size_next = rd_size;
        if (!rd_free) begin
          pos_next   = foll;
          state_next = S_C_RD;
        end else if (foll >= PW'(GRANULES)) begin
          fin        = 1'b1;
          fin_ok     = 1'b1;
          state_next = S_IDLE;
        end else begin
          // Fetch the neighbor that follows this free block
          rd_en      = 1'b1;
          rd_addr    = foll[IW-1:0];
          state_next = S_C_NCHK;
        end
      end

      S_C_NCHK: begin
        if (rd_free) begin
          // Absorb the neighbor and look at the next one
          cur_size_next = merged;
          wr_en         = 1'b1;
          wr_data       = {1'b1, merged};
          if (merged_foll >= PW'(GRANULES)) begin
            fin        = 1'b1;
            fin_ok     = 1'b1;
            state_next = S_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = merged_foll[IW-1:0];
          end
        end else begin
          // Neighbor is in use: skip past it
          pos_next   = pos + PW'(2) + PW'(cur_size) + PW'(rd_size);
          state_next = S_C_RD;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= fin;
    end
  end

  // Working and result registers
  always_ff @(posedge clk) begin
    pos      <= pos_next;
    target   <= target_next;
    need     <= need_next;
    cur_size <= cur_size_next;
    if (fin) begin
      success        <= fin_ok;
      granted_offset <= fin_off;
    end
  end

  assign busy = (state != S_IDLE);

endmodule
